FILE: hdl/zlcf_pkg.sv
// Package for the zone LED color fader: zone state type, fade and ring constants.
// Used by every module of the block but the checker; depends on nothing.
package zlcf_pkg;

    localparam int ZONE_COUNT = 6;
    localparam int ZIDX_W     = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
    localparam int ZONE_W     = 3;
    localparam int BYTE_W     = 8;
    localparam int LED_W      = 8;

    // Byte lanes of a zone record
    localparam int LANES    = 4;
    localparam int LANE_RED = 3;
    localparam int LANE_GRN = 2;
    localparam int LANE_BLU = 1;
    localparam int LANE_LVL = 0;

    // Divide by 5 through a reciprocal: exact for 8-bit magnitudes
    localparam int FADE_MUL_W = 8;
    localparam logic [FADE_MUL_W-1:0] FADE_RECIP = 8'd205;
    localparam int FADE_SHIFT = 10;

    // Ring spans; zones past the table get the empty span at the limit
    localparam int SPAN_IDX_W   = 5;
    localparam int RING_ENTRIES = 7;
    localparam logic [LED_W-1:0] RING_LIMIT = 8'd160;
    localparam logic [RING_ENTRIES-1:0][LED_W-1:0] RING_EDGE =
        {8'd160, 8'd116, 8'd80, 8'd48, 8'd24, 8'd8, 8'd0};

    typedef logic [LANES-1:0][BYTE_W-1:0] lanes_t;

    typedef struct packed {
        lanes_t now;
        lanes_t goal;
    } zone_state_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic jump;
    } cell_ctrl_t;

    function automatic logic [LED_W-1:0] ring_bound(input logic [SPAN_IDX_W-1:0] idx);
        logic [LED_W-1:0] edge_val;
        if (idx < SPAN_IDX_W'(RING_ENTRIES))
        begin
            edge_val = RING_EDGE[idx[2:0]];
        end
        else
        begin
            edge_val = RING_LIMIT;
        end
        return edge_val;
    endfunction

endpackage

FILE: hdl/zlcf_cell.sv
// One link of the zone ring: holds a zone's current and goal bytes.
// Loads from a set beat, or takes its neighbor's record while the ring turns. Uses zlcf_pkg.
module zlcf_cell
    import zlcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_ctrl_t  ctrl,
    input  lanes_t      set_val,
    input  zone_state_t shift_in,
    output zone_state_t state
);

    zone_state_t state_reg;
    zone_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        if (ctrl.load)
        begin
            state_next.goal = set_val;
            if (ctrl.jump)
            begin
                state_next.now = set_val;
            end
        end
        else if (ctrl.shift)
        begin
            state_next = shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

FILE: hdl/zlcf_step.sv
// Fade step: moves each current byte toward its goal by (goal - current) / 5.
// Truncates toward zero; four lanes in parallel. Uses zlcf_pkg.
module zlcf_step
    import zlcf_pkg::*;
(
    input  zone_state_t head,
    output zone_state_t advanced
);

    logic [LANES-1:0][BYTE_W:0]             diff;
    logic [LANES-1:0][BYTE_W-1:0]           mag;
    logic [LANES-1:0][BYTE_W+FADE_MUL_W-1:0] prod;
    logic [LANES-1:0][BYTE_W-1:0]           quot;

    always_comb
    begin
        advanced.goal = head.goal;
        for (int i = 0; i < LANES; i++)
        begin
            diff[i] = {1'b0, head.goal[i]} - {1'b0, head.now[i]};
            mag[i]  = diff[i][BYTE_W] ? BYTE_W'(-diff[i]) : diff[i][BYTE_W-1:0];
            prod[i] = mag[i] * FADE_RECIP;
            quot[i] = BYTE_W'(prod[i] >> FADE_SHIFT);
            advanced.now[i] = diff[i][BYTE_W] ? (head.now[i] - quot[i])
                                              : (head.now[i] + quot[i]);
        end
    end

endmodule

FILE: hdl/zlcf_scale.sv
// Output stage: brightness scaling with video rounding plus the zone's LED span.
// Registers one result beat per zone. Uses zlcf_pkg.
module zlcf_scale
    import zlcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [ZIDX_W-1:0] in_zone,
    input  logic              in_last,
    input  lanes_t            in_now,
    output logic              strobe,
    output logic [ZONE_W-1:0] out_zone,
    output logic [BYTE_W-1:0] pixel_red,
    output logic [BYTE_W-1:0] pixel_green,
    output logic [BYTE_W-1:0] pixel_blue,
    output logic [LED_W-1:0]  first_led,
    output logic [LED_W-1:0]  end_led,
    output logic              last
);

    logic [2:0][2*BYTE_W-1:0] prod;
    logic [2:0][BYTE_W-1:0]   pix;
    logic [2:0][BYTE_W-1:0]   chan;
    logic [BYTE_W-1:0]        level;

    logic                     strobe_reg;
    logic [ZONE_W-1:0]        zone_reg;
    logic [2:0][BYTE_W-1:0]   pix_reg;
    logic [LED_W-1:0]         first_reg;
    logic [LED_W-1:0]         end_reg;
    logic                     last_reg;

    always_comb
    begin
        chan[2] = in_now[LANE_RED];
        chan[1] = in_now[LANE_GRN];
        chan[0] = in_now[LANE_BLU];
        level   = in_now[LANE_LVL];
        for (int i = 0; i < 3; i++)
        begin
            prod[i] = chan[i] * level;
            if ((chan[i] == '0) || (level == '0))
            begin
                pix[i] = '0;
            end
            else
            begin
                pix[i] = prod[i][2*BYTE_W-1:BYTE_W] + BYTE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            zone_reg  <= ZONE_W'(in_zone);
            pix_reg   <= pix;
            first_reg <= ring_bound(SPAN_IDX_W'(in_zone));
            end_reg   <= ring_bound(SPAN_IDX_W'(in_zone) + SPAN_IDX_W'(1));
            last_reg  <= in_last;
        end
    end

    assign strobe      = strobe_reg;
    assign out_zone    = zone_reg;
    assign pixel_red   = pix_reg[2];
    assign pixel_green = pix_reg[1];
    assign pixel_blue  = pix_reg[0];
    assign first_led   = first_reg;
    assign end_led     = end_reg;
    assign last        = last_reg;

endmodule

FILE: hdl/zone_led_color_fader_top.sv
// Top level of the zone LED color fader: ring of zone cells, fade step, output stage.
// Depends on zlcf_pkg, zlcf_cell, zlcf_step and zlcf_scale.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------------------------
//  command   | start / busy       | op, zone, goal_red/green/blue, goal_level, jump_now
//  result    | strobe (one cycle) | out_zone, pixel_red/green/blue, first_led, end_led,
//            |                    | last
//
// A beat is taken at a rising edge with start high and busy low.
// Set beat (op 0): written into the addressed cell at that edge, no result.
// Tick beat (op 1): the ring turns once, one zone per cycle; each result is registered in
// the s1 stage, then in the scaler's output register; busy holds until s1 drains.
// Reset (rst_n low, asynchronous) clears all zone bytes to zero and empties the pipe.
// Results cannot be held off: each strobe beat is on the ports for exactly one cycle.
module zone_led_color_fader_top
    import zlcf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              op,
    input  logic [ZONE_W-1:0] zone,
    input  logic [BYTE_W-1:0] goal_red,
    input  logic [BYTE_W-1:0] goal_green,
    input  logic [BYTE_W-1:0] goal_blue,
    input  logic [BYTE_W-1:0] goal_level,
    input  logic              jump_now,
    output logic              strobe,
    output logic [ZONE_W-1:0] out_zone,
    output logic [BYTE_W-1:0] pixel_red,
    output logic [BYTE_W-1:0] pixel_green,
    output logic [BYTE_W-1:0] pixel_blue,
    output logic [LED_W-1:0]  first_led,
    output logic [LED_W-1:0]  end_led,
    output logic              last
);

    localparam logic [ZIDX_W-1:0] CNT_LAST = ZIDX_W'(ZONE_COUNT - 1);

    // Command decode
    logic   accept;
    logic   set_go;
    logic   tick_go;
    lanes_t set_val;

    // Ring sequencing: cell 0 is the head, its advanced record re-enters at the tail
    logic              run_reg;
    logic              run_next;
    logic [ZIDX_W-1:0] cnt_reg;
    logic [ZIDX_W-1:0] cnt_next;

    // Stage between fade step and scaler (breaks the two multiplier levels)
    logic              s1_valid_reg;
    logic [ZIDX_W-1:0] s1_zone_reg;
    logic              s1_last_reg;
    lanes_t            s1_now_reg;

    zone_state_t cell_q [ZONE_COUNT];
    zone_state_t head_adv;

    assign accept  = start && !busy;
    assign set_go  = accept && !op;
    assign tick_go = accept && op;
    assign busy    = run_reg || s1_valid_reg;

    always_comb
    begin
        set_val[LANE_RED] = goal_red;
        set_val[LANE_GRN] = goal_green;
        set_val[LANE_BLU] = goal_blue;
        set_val[LANE_LVL] = goal_level;
    end

    // The cells
    for (genvar i = 0; i < ZONE_COUNT; i++)
    begin : g_cell
        cell_ctrl_t  ctrl;
        zone_state_t shift_in;

        // Out-of-range zones match no cell and are dropped
        assign ctrl.shift = run_reg;
        assign ctrl.load  = set_go && (int'(zone) == i);
        assign ctrl.jump  = jump_now;

        if (i == ZONE_COUNT - 1)
        begin : g_tail
            assign shift_in = head_adv;
        end
        else
        begin : g_link
            assign shift_in = cell_q[i+1];
        end

        zlcf_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .set_val  (set_val),
            .shift_in (shift_in),
            .state    (cell_q[i])
        );
    end

    zlcf_step u_step (
        .head     (cell_q[0]),
        .advanced (head_adv)
    );

    // Turn counter: head holds zone cnt_reg during each run cycle
    always_comb
    begin
        run_next = run_reg;
        cnt_next = cnt_reg;
        if (run_reg)
        begin
            cnt_next = cnt_reg + ZIDX_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                run_next = 1'b0;
                cnt_next = '0;
            end
        end
        else if (tick_go)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg      <= 1'b0;
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg      <= run_next;
            cnt_reg      <= cnt_next;
            s1_valid_reg <= run_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run_reg)
        begin
            s1_zone_reg <= cnt_reg;
            s1_last_reg <= (cnt_reg == CNT_LAST);
            s1_now_reg  <= head_adv.now;
        end
    end

    zlcf_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s1_valid_reg),
        .in_zone     (s1_zone_reg),
        .in_last     (s1_last_reg),
        .in_now      (s1_now_reg),
        .strobe      (strobe),
        .out_zone    (out_zone),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .first_led   (first_led),
        .end_led     (end_led),
        .last        (last)
    );

endmodule

FILE: hdl/zlcf_checker.sv
// Port-level checks for the zone LED color fader, bound to the top level.
// Depends on zone_led_color_fader_top's port list.
module zlcf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       op,
    input logic       strobe,
    input logic [2:0] out_zone,
    input logic       last
);

    // A tick's beats come back to back until the last one
    a_burst_dense: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("result burst broke before last beat");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result beat after last");

    a_zone_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> out_zone == 3'($past(out_zone) + 3'd1))
        else $error("zones out of order");

    a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !op |=> !strobe)
        else $error("set beat produced a result");

    a_tick_first: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && op |=> ##2 (strobe && out_zone == 3'd0))
        else $error("tick did not start results at zone zero");

endmodule

bind zone_led_color_fader_top zlcf_checker u_zlcf_checker (.*);

FILE: sim/zone_led_color_fader_top_tb.sv
`timescale 1ns / 100ps
// Testbench for zone_led_color_fader_top: directed and random set/tick beats, every result
// checked field by field against an in-bench fade predictor. Depends on zlcf_pkg and the RTL.
module zone_led_color_fader_top_tb;
    import zlcf_pkg::*;

    // Command opcodes on the op port
    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Byte lanes of the predictor's per-zone store
    localparam int CH_RED = 0;
    localparam int CH_GRN = 1;
    localparam int CH_BLU = 2;
    localparam int CH_LVL = 3;

    // Ring span edges; zone z covers [edge z, edge z+1)
    localparam logic [6:0][7:0] SPAN_EDGE =
        {8'd160, 8'd116, 8'd80, 8'd48, 8'd24, 8'd8, 8'd0};

    localparam int RANDOM_BEATS = 420;
    localparam int IDLE_LIMIT   = 3000;   // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 20;     // margin after the result queue drains
    localparam int PRINT_CAP    = 40;

    // One command beat plus an optional hand-typed pixel for one zone of a tick
    typedef struct packed {
        logic        op;
        logic [2:0]  zone;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  level;
        logic        jump;
        logic        pin_on;
        logic [2:0]  pin_zone;
        logic [23:0] pin_rgb;
    } beat_t;

    typedef struct packed {
        logic [2:0] zone;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] lo_led;
        logic [7:0] hi_led;
        logic       fin;
    } pixel_t;

    localparam int DIR_ROWS = 24;

    // Directed table. Pinned pixels are the ones obvious by inspection:
    // all black after reset, full white, brightness zero, level one, half blue.
    localparam beat_t DIR_TABLE [DIR_ROWS] = '{
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd0, 24'h000000},
        '{OP_SET,  3'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd0, 24'hffffff},
        '{OP_SET,  3'd5, 8'h80, 8'h01, 8'h00, 8'h00, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd5, 24'h000000},
        '{OP_SET,  3'd6, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_SET,  3'd7, 8'h5a, 8'ha5, 8'h3c, 8'hc3, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_SET,  3'd1, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_SET,  3'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_SET,  3'd2, 8'h01, 8'h02, 8'h03, 8'h01, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd2, 24'h010101},
        '{OP_SET,  3'd3, 8'h00, 8'h00, 8'hff, 8'h80, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 3'd3, 24'h000080},
        '{OP_SET,  3'd4, 8'h10, 8'h20, 8'h30, 8'h01, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_SET,  3'd4, 8'h14, 8'h1c, 8'h34, 8'h05, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd7, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 3'd0, 24'h000000},
        '{OP_SET,  3'd5, 8'haa, 8'h55, 8'haa, 8'h55, 1'b0, 1'b0, 3'd0, 24'h000000},
        '{OP_TICK, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 3'd0, 24'h000000}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              op = OP_SET;
    logic [ZONE_W-1:0] zone = '0;
    logic [BYTE_W-1:0] goal_red = '0;
    logic [BYTE_W-1:0] goal_green = '0;
    logic [BYTE_W-1:0] goal_blue = '0;
    logic [BYTE_W-1:0] goal_level = '0;
    logic              jump_now = 1'b0;
    logic              strobe;
    logic [ZONE_W-1:0] out_zone;
    logic [BYTE_W-1:0] pixel_red;
    logic [BYTE_W-1:0] pixel_green;
    logic [BYTE_W-1:0] pixel_blue;
    logic [LED_W-1:0]  first_led;
    logic [LED_W-1:0]  end_led;
    logic              last;

    zone_led_color_fader_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .zone        (zone),
        .goal_red    (goal_red),
        .goal_green  (goal_green),
        .goal_blue   (goal_blue),
        .goal_level  (goal_level),
        .jump_now    (jump_now),
        .strobe      (strobe),
        .out_zone    (out_zone),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .first_led   (first_led),
        .end_led     (end_led),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor store: current and goal bytes per zone, lanes CH_*
    logic [7:0] zone_now  [ZONE_COUNT][4];
    logic [7:0] zone_goal [ZONE_COUNT][4];

    pixel_t pixel_q[$];   // pixels owed by accepted ticks, oldest first
    beat_t  pin_q[$];     // one entry per driven beat, popped when the beat is taken
    int     errors = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    int     beats_sent = 0;

    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= PRINT_CAP)
        begin
            $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
        end
    endtask

    // One fade step: move toward the goal by a fifth of the gap, truncated toward zero
    function automatic logic [7:0] fade_toward(input logic [7:0] cur, input logic [7:0] tgt);
        int gap;
        gap = int'(tgt) - int'(cur);
        return 8'(int'(cur) + gap / 5);
    endfunction

    // Video dimming: nonzero channel never drops to zero while brightness is nonzero
    function automatic logic [7:0] video_dim(input logic [7:0] chan, input logic [7:0] lvl);
        logic [15:0] prod;
        prod = 16'(chan) * 16'(lvl);
        if (chan == 8'd0 || lvl == 8'd0)
        begin
            return 8'd0;
        end
        return prod[15:8] + 8'd1;
    endfunction

    // Applies one accepted beat to the predictor store and queues the pixels it owes
    task automatic take_beat(input beat_t b);
        pixel_t px;
        if (b.op == OP_SET)
        begin
            if (int'(b.zone) < ZONE_COUNT)
            begin
                zone_goal[b.zone][CH_RED] = b.red;
                zone_goal[b.zone][CH_GRN] = b.green;
                zone_goal[b.zone][CH_BLU] = b.blue;
                zone_goal[b.zone][CH_LVL] = b.level;
                if (b.jump)
                begin
                    zone_now[b.zone] = zone_goal[b.zone];
                end
            end
        end
        else
        begin
            // all zones fade first, then every zone reports in order
            for (int z = 0; z < ZONE_COUNT; z++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    zone_now[z][c] = fade_toward(zone_now[z][c], zone_goal[z][c]);
                end
            end
            for (int z = 0; z < ZONE_COUNT; z++)
            begin
                px.zone   = 3'(z);
                px.red    = video_dim(zone_now[z][CH_RED], zone_now[z][CH_LVL]);
                px.green  = video_dim(zone_now[z][CH_GRN], zone_now[z][CH_LVL]);
                px.blue   = video_dim(zone_now[z][CH_BLU], zone_now[z][CH_LVL]);
                px.lo_led = SPAN_EDGE[z];
                px.hi_led = SPAN_EDGE[z + 1];
                px.fin    = (z == ZONE_COUNT - 1);
                if (b.pin_on && int'(b.pin_zone) == z)
                begin
                    // hand-typed pixel wins; disagreement means the predictor is off
                    if ({px.red, px.green, px.blue} != b.pin_rgb)
                    begin
                        flag_mismatch("typed pixel vs predictor", {px.red, px.green, px.blue},
                                      b.pin_rgb);
                    end
                    {px.red, px.green, px.blue} = b.pin_rgb;
                end
                pixel_q.push_back(px);
            end
        end
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (pixel_q.size() == 0)
        begin
            flag_mismatch("unexpected result, zone", out_zone, 0);
        end
        else
        begin
            want = pixel_q.pop_front();
            if (out_zone != want.zone)      flag_mismatch("out_zone", out_zone, want.zone);
            if (pixel_red != want.red)      flag_mismatch("pixel_red", pixel_red, want.red);
            if (pixel_green != want.green)  flag_mismatch("pixel_green", pixel_green, want.green);
            if (pixel_blue != want.blue)    flag_mismatch("pixel_blue", pixel_blue, want.blue);
            if (first_led != want.lo_led)   flag_mismatch("first_led", first_led, want.lo_led);
            if (end_led != want.hi_led)     flag_mismatch("end_led", end_led, want.hi_led);
            if (last != want.fin)           flag_mismatch("last", last, want.fin);
        end
    endtask

    // Monitor: sample at the edge, before any nonblocking update lands.
    // The result beat is checked before a new tick is taken at the same edge.
    always @(posedge clk)
    begin : monitor
        beat_t taken;
        if (rst_n)
        begin
            if (strobe)
            begin
                check_pixel();
            end
            if (start && !busy)
            begin
                taken = pin_q.pop_front();
                taken.op    = op;
                taken.zone  = zone;
                taken.red   = goal_red;
                taken.green = goal_green;
                taken.blue  = goal_blue;
                taken.level = goal_level;
                taken.jump  = jump_now;
                take_beat(taken);
            end
        end
    end

    // Watchdog: any command or result beat counts as progress
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("zone_led_color_fader_top test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return 8'($urandom_range(0, 7));
            default: return 8'($urandom);
        endcase
    endfunction

    // Random beat: mostly sets into valid zones, a third ticks, a few out-of-range sets
    function automatic beat_t random_beat();
        beat_t b;
        b          = '0;
        b.op       = ($urandom_range(0, 99) < 35) ? OP_TICK : OP_SET;
        b.zone     = ($urandom_range(0, 99) < 6) ? 3'($urandom_range(6, 7))
                                                  : 3'($urandom_range(0, ZONE_COUNT - 1));
        b.red      = pick_byte();
        b.green    = pick_byte();
        b.blue     = pick_byte();
        b.level    = pick_byte();
        b.jump     = ($urandom_range(0, 3) == 0);
        return b;
    endfunction

    // Sender pacing: bursts of random length, random gaps, one stretch with no gaps.
    // Called at a clock edge right after a beat was taken.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 6);
            if (beats_sent >= 150 && beats_sent < 230)
            begin
                gap = 0;
            end
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // Drives one beat at the current edge and returns at the edge that takes it
    task automatic send_beat(input beat_t b);
        pin_q.push_back(b);
        op         <= b.op;
        zone       <= b.zone;
        goal_red   <= b.red;
        goal_green <= b.green;
        goal_blue  <= b.blue;
        goal_level <= b.level;
        jump_now   <= b.jump;
        start      <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        beats_sent++;
    endtask

    initial
    begin : stimulus
        beat_t b;
        int    counted;
        for (int z = 0; z < ZONE_COUNT; z++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                zone_now[z][c]  = 8'd0;
                zone_goal[z][c] = 8'd0;
            end
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i > 0)
            begin
                pace_sender();
            end
            send_beat(DIR_TABLE[i]);
        end

        // ignored sets (zone past the ring) do not count toward the total
        counted = 0;
        while (counted < RANDOM_BEATS)
        begin
            b = random_beat();
            pace_sender();
            send_beat(b);
            if (b.op == OP_TICK || int'(b.zone) < ZONE_COUNT)
            begin
                counted++;
            end
        end
        start <= 1'b0;

        while (pixel_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
        begin
            $display("zone_led_color_fader_top test passed");
        end
        else
        begin
            $display("zone_led_color_fader_top test failed");
        end
        $finish;
    end

endmodule
